// ===== src/vcv_pkg.sv =====
// Shared constants and types for the vertex transform core.
// No dependencies; used by the top level and the pipelined divider.
package vcv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VP_W          = 13;
    localparam int VAL_W         = 32;
    localparam int CFG_IDX_W     = 1;

    localparam logic [VP_W-1:0] VP_WIDTH_RST  = 13'd800;
    localparam logic [VP_W-1:0] VP_HEIGHT_RST = 13'd600;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSFORM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 1'b1;

    localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                    vld;
        logic                    sat;
        logic signed [VAL_W-1:0] cx;
        logic signed [VAL_W-1:0] cy;
        logic signed [VAL_W-1:0] cz;
        logic signed [VAL_W-1:0] cw;
    } t_side;

endpackage

// ===== src/vertex_clip_ndc_viewport_core.sv =====
// Top level of the vertex transform core: matrix multiply, perspective divide, viewport map.
// Depends on vcv_pkg and vcv_div.
//
// The core accepts one transfer per cycle whenever the output is free or being taken. A load
// transfer writes one coefficient of the column-major Q matrix and yields nothing; a transform
// transfer yields one result once it has passed the input, product, row-sum and clip registers,
// the bit-per-stage divider that forms the NDC quotients and the NDC, screen product and output
// registers. The matrix resets to identity and the viewport to 800 x 600.
module vertex_clip_ndc_viewport_core #(
    parameter int FRAC_BITS = vcv_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100],
    // pos_w[163:132], zero fill above
    input  logic [167:0]                      i_s_tdata,
    // cmd
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // clip_x, clip_y, clip_z, clip_w, ndc_x, ndc_y, ndc_z, screen_x, screen_y, 32 bits each
    output logic [287:0]                      o_m_tdata,
    // divide_fault[0], saturated[1]
    output logic [1:0]                        o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [vcv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vcv_pkg::VP_W-1:0]          i_cfg_wdata
);

    localparam int NW = 32 + FRAC_BITS;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic en, acc;
    logic [vcv_pkg::VP_W-1:0] r_vp_w, r_vp_h;
    logic signed [31:0] r_coef [16];

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_w <= vcv_pkg::VP_WIDTH_RST;
            r_vp_h <= vcv_pkg::VP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vcv_pkg::CFG_VP_WIDTH:  r_vp_w <= i_cfg_wdata;
                vcv_pkg::CFG_VP_HEIGHT: r_vp_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_coef[i] <= (i % 5 == 0) ? ONE : 32'd0;
            end
        end else if (acc && i_s_tuser == vcv_pkg::CMD_LOAD) begin
            r_coef[i_s_tdata[3:0]] <= i_s_tdata[35:4];
        end
    end

    // Stage 1: input register.
    logic               r_s1_vld;
    logic signed [31:0] r_s1_pos [4];
    // Stage 2: products.
    logic               r_s2_vld;
    logic signed [63:0] r_s2_prod [4][4];
    // Stage 3: row sums.
    logic               r_s3_vld;
    logic signed [65:0] r_s3_sum [4];
    // Stage 4: clip values.
    logic               r_s4_vld, r_s4_sat;
    logic signed [31:0] r_clip [4];

    logic signed [65:0] sh [4];
    logic [3:0]         clip_ovf;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sh[r]       = r_s3_sum[r] >>> FRAC_BITS;
            clip_ovf[r] = !((&sh[r][65:31]) || !(|sh[r][65:31]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= acc && i_s_tuser == vcv_pkg::CMD_TRANSFORM;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pos[0] <= i_s_tdata[67:36];
            r_s1_pos[1] <= i_s_tdata[99:68];
            r_s1_pos[2] <= i_s_tdata[131:100];
            r_s1_pos[3] <= i_s_tdata[163:132];
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_s2_prod[r][c] <= 64'(r_coef[c*4+r]) * 64'(r_s1_pos[c]);
                end
                r_s3_sum[r] <= 66'(r_s2_prod[r][0]) + 66'(r_s2_prod[r][1])
                             + 66'(r_s2_prod[r][2]) + 66'(r_s2_prod[r][3]);
                r_clip[r] <= clip_ovf[r] ? (sh[r][65] ? vcv_pkg::S32_MIN : vcv_pkg::S32_MAX)
                                         : sh[r][31:0];
            end
            r_s4_sat <= |clip_ovf;
        end
    end

    // Divider lanes.
    logic [31:0]    abs_w;
    logic [31:0]    abs_c [3];
    logic [NW-1:0]  quo [3];
    vcv_pkg::t_side side_in;
    vcv_pkg::t_side r_dly [NW];

    assign abs_w = r_clip[3][31] ? 32'(-r_clip[3]) : r_clip[3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            assign abs_c[g] = r_clip[g][31] ? 32'(-r_clip[g]) : r_clip[g];
            vcv_div #(.NUM_W(NW)) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (NW'(abs_c[g]) << FRAC_BITS),
                .i_den (abs_w),
                .o_quo (quo[g])
            );
        end
    endgenerate

    assign side_in = '{vld: r_s4_vld, sat: r_s4_sat,
                       cx: r_clip[0], cy: r_clip[1], cz: r_clip[2], cw: r_clip[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NW; i++) begin
                r_dly[i].vld <= 1'b0;
            end
        end else if (en) begin
            r_dly[0] <= side_in;
            for (int i = 1; i < NW; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // NDC stage.
    vcv_pkg::t_side d;
    logic signed [31:0] dc [3];
    logic signed [31:0] n_ndc [3];
    logic [2:0]         ndc_sat;
    logic               fault;

    assign d     = r_dly[NW-1];
    assign dc[0] = d.cx;
    assign dc[1] = d.cy;
    assign dc[2] = d.cz;
    assign fault = (d.cw == 32'sd0);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (fault) begin
                ndc_sat[r] = (dc[r] != 32'sd0);
                n_ndc[r]   = (dc[r] == 32'sd0) ? 32'sd0
                           : (dc[r][31] ? vcv_pkg::S32_MIN : vcv_pkg::S32_MAX);
            end else if (dc[r][31] ^ d.cw[31]) begin
                ndc_sat[r] = (|quo[r][NW-1:32]) || (quo[r][31] && (|quo[r][30:0]));
                n_ndc[r]   = ndc_sat[r] ? vcv_pkg::S32_MIN : 32'(-quo[r][31:0]);
            end else begin
                ndc_sat[r] = |quo[r][NW-1:31];
                n_ndc[r]   = ndc_sat[r] ? vcv_pkg::S32_MAX : quo[r][31:0];
            end
        end
    end

    logic               r_n_vld, r_n_sat, r_n_fault;
    logic signed [31:0] r_n_clip [4];
    logic signed [31:0] r_ndc [3];
    // Screen product stage.
    logic               r_p_vld, r_p_sat, r_p_fault;
    logic signed [31:0] r_p_clip [4];
    logic signed [31:0] r_p_ndc [3];
    logic signed [46:0] r_p_prod [2];
    logic signed [32:0] ndc_off [2];

    assign ndc_off[0] = 33'(r_ndc[0]) + $signed({1'b0, ONE});
    assign ndc_off[1] = 33'(r_ndc[1]) + $signed({1'b0, ONE});

    // Output stage.
    logic signed [46:0] scr_sh [2];
    logic [1:0]         scr_ovf;
    logic signed [31:0] scr [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            scr_sh[i]  = r_p_prod[i] >>> 1;
            scr_ovf[i] = !((&scr_sh[i][46:31]) || !(|scr_sh[i][46:31]));
            scr[i]     = scr_ovf[i] ? (scr_sh[i][46] ? vcv_pkg::S32_MIN : vcv_pkg::S32_MAX)
                                    : scr_sh[i][31:0];
        end
    end

    logic r_o_vld;
    assign o_m_tvalid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_n_vld <= d.vld;
            r_p_vld <= r_n_vld;
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_sat     <= d.sat || (|ndc_sat);
            r_n_fault   <= fault;
            r_n_clip[0] <= d.cx;
            r_n_clip[1] <= d.cy;
            r_n_clip[2] <= d.cz;
            r_n_clip[3] <= d.cw;
            r_ndc       <= n_ndc;
            r_p_sat     <= r_n_sat;
            r_p_fault   <= r_n_fault;
            r_p_clip    <= r_n_clip;
            r_p_ndc     <= r_ndc;
            r_p_prod[0] <= 47'(ndc_off[0]) * $signed({34'd0, r_vp_w});
            r_p_prod[1] <= 47'(ndc_off[1]) * $signed({34'd0, r_vp_h});
            o_m_tdata   <= {scr[1], scr[0], r_p_ndc[2], r_p_ndc[1], r_p_ndc[0],
                            r_p_clip[3], r_p_clip[2], r_p_clip[1], r_p_clip[0]};
            o_m_tuser   <= {r_p_sat || (|scr_ovf), r_p_fault};
        end
    end

endmodule

// ===== src/vcv_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses vcv_pkg for the divisor width; every stage is registered and advances only while i_en is high.
module vcv_div #(
    parameter int NUM_W = 48
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [vcv_pkg::VAL_W-1:0]    i_den,
    output logic [NUM_W-1:0]             o_quo
);

    localparam int DW = vcv_pkg::VAL_W;

    logic [DW-1:0]    r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DW-1:0]    r_den [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [DW-1:0]    rem_in;
            logic [NUM_W-1:0] num_in;
            logic [DW-1:0]    den_in;
            logic [DW:0]      t;
            logic [DW:0]      diff;
            logic             qb;
            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = i_num;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign num_in = r_num[k-1];
                assign den_in = r_den[k-1];
            end
            assign t    = {rem_in, num_in[NUM_W-1]};
            assign diff = t - {1'b0, den_in};
            assign qb   = (t >= {1'b0, den_in});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= qb ? diff[DW-1:0] : t[DW-1:0];
                    r_num[k] <= {num_in[NUM_W-2:0], qb};
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_num[NUM_W-1];

endmodule

// ===== test/vertex_clip_ndc_viewport_core_tb.sv =====
// Self-checking testbench for vertex_clip_ndc_viewport_core: matrix loads, vertex transforms,
// perspective divide and viewport mapping, checked against an in-bench predictor.
// Depends on vcv_pkg and the core; reads no files.
module vertex_clip_ndc_viewport_core_tb;

    localparam int FB = vcv_pkg::FRAC_BITS_DEF;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] cx, cy, cz, cw, nx, ny, nz, sx, sy;
        logic        fault;
        logic        sat;
    } t_vertex_out;

    typedef struct {
        logic         cmd;
        logic [3:0]   idx;
        logic [31:0]  val;
        logic [31:0]  p [4];
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [167:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [287:0] o_m_tdata;
    logic [1:0] o_m_tuser;
    logic i_cfg_we = 1'b0;
    logic [vcv_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [vcv_pkg::VP_W-1:0] i_cfg_wdata = '0;

    vertex_clip_ndc_viewport_core u_dut (.*);

    t_item       pending_items[$];
    t_vertex_out expected_vertices[$];
    logic [31:0] mat_model [16];
    logic [12:0] vp_w_model, vp_h_model;
    int          send_idle_pct, recv_idle_pct;
    int          errors, n_loads, n_xforms, n_faults, n_sats, quiet_cycles;
    bit          in_flight;
    t_item       cur;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_s32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_vertex_out transform_vertex(t_item it);
        t_vertex_out o;
        bit          sat, fault;
        longint      clip [4];
        longint      ndc [3];
        longint      s0, s1, num;
        longint      acc_hi, acc_lo, pr;
        sat = 0;
        fault = 0;
        for (int r = 0; r < 4; r++) begin
            acc_hi = 0;
            acc_lo = 0;
            for (int c = 0; c < 4; c++) begin
                pr = longint'($signed(mat_model[c*4+r])) * longint'($signed(it.p[c]));
                acc_hi += pr >>> 2;
                acc_lo += pr - ((pr >>> 2) * 4);
            end
            clip[r] = clamp_s32((acc_hi + (acc_lo >>> 2)) >>> (FB - 2), sat);
        end
        for (int r = 0; r < 3; r++) begin
            if (clip[3] == 0) begin
                fault = 1;
                if (clip[r] > 0) begin
                    ndc[r] = 64'sd2147483647;
                    sat = 1;
                end else if (clip[r] < 0) begin
                    ndc[r] = -64'sd2147483648;
                    sat = 1;
                end else begin
                    ndc[r] = 0;
                end
            end else begin
                num = clip[r] * (64'sd1 <<< FB);
                ndc[r] = clamp_s32(num / clip[3], sat);
            end
        end
        s0 = clamp_s32(((ndc[0] + (64'sd1 <<< FB)) * longint'(vp_w_model)) >>> 1, sat);
        s1 = clamp_s32(((ndc[1] + (64'sd1 <<< FB)) * longint'(vp_h_model)) >>> 1, sat);
        o.cx = clip[0][31:0];
        o.cy = clip[1][31:0];
        o.cz = clip[2][31:0];
        o.cw = clip[3][31:0];
        o.nx = ndc[0][31:0];
        o.ny = ndc[1][31:0];
        o.nz = ndc[2][31:0];
        o.sx = s0[31:0];
        o.sy = s1[31:0];
        o.fault = fault;
        o.sat = sat;
        return o;
    endfunction

    function automatic void check_word(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v != act_v) begin
            $error("%s exp %h got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(logic [3:0] idx, logic [31:0] val);
        t_item it;
        it.cmd = vcv_pkg::CMD_LOAD;
        it.idx = idx;
        it.val = val;
        for (int k = 0; k < 4; k++) it.p[k] = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
        t_item it;
        it.cmd = vcv_pkg::CMD_TRANSFORM;
        it.idx = 4'($urandom);
        it.val = $urandom;
        it.p[0] = x;
        it.p[1] = y;
        it.p[2] = z;
        it.p[3] = w;
        pending_items.push_back(it);
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 25) begin
                push_load(4'($urandom_range(0, 15)), rand_word());
            end else if ($urandom_range(0, 9) == 0) begin
                push_vertex(rand_word(), rand_word(), rand_word(), rand_word());
            end else begin
                push_vertex($urandom_range(0, 32'h00A0_0000) - 32'h0050_0000,
                            $urandom_range(0, 32'h00A0_0000) - 32'h0050_0000,
                            $urandom_range(0, 32'h00A0_0000) - 32'h0050_0000,
                            $urandom_range(32'h0000_8000, 32'h0004_0000));
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_flight || expected_vertices.size() != 0)
            @(posedge i_clk);
        repeat (7 + 32 + FB + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [vcv_pkg::CFG_IDX_W-1:0] idx, logic [vcv_pkg::VP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vcv_pkg::CFG_VP_WIDTH) vp_w_model = val;
        else vp_h_model = val;
    endtask

    // Driver: items leave the queue at the falling edge and are held until the transfer.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_flight && pending_items.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                cur = pending_items.pop_front();
                i_s_tuser <= cur.cmd;
                i_s_tdata <= {4'b0, cur.p[3], cur.p[2], cur.p[1], cur.p[0], cur.val, cur.idx};
                i_s_tvalid <= 1'b1;
                in_flight = 1;
            end else if (!in_flight) begin
                i_s_tvalid <= 1'b0;
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on each accepted input and checks each accepted result.
    always @(posedge i_clk) begin
        t_vertex_out got, want;
        bit          moved;
        if (i_rst_n) begin
            moved = 0;
            if (i_s_tvalid && o_s_tready) begin
                moved = 1;
                in_flight = 0;
                if (cur.cmd == vcv_pkg::CMD_LOAD) begin
                    mat_model[cur.idx] = cur.val;
                    n_loads++;
                end else begin
                    want = transform_vertex(cur);
                    expected_vertices.push_back(want);
                    n_xforms++;
                    n_faults += want.fault;
                    n_sats += want.sat;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1;
                got = {o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[95:64],
                       o_m_tdata[127:96], o_m_tdata[159:128], o_m_tdata[191:160],
                       o_m_tdata[223:192], o_m_tdata[255:224], o_m_tdata[287:256],
                       o_m_tuser[0], o_m_tuser[1]};
                if (expected_vertices.size() == 0) begin
                    $error("unexpected result %h", o_m_tdata);
                    errors++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_word("clip_x", want.cx, got.cx);
                    check_word("clip_y", want.cy, got.cy);
                    check_word("clip_z", want.cz, got.cz);
                    check_word("clip_w", want.cw, got.cw);
                    check_word("ndc_x", want.nx, got.nx);
                    check_word("ndc_y", want.ny, got.ny);
                    check_word("ndc_z", want.nz, got.nz);
                    check_word("screen_x", want.sx, got.sx);
                    check_word("screen_y", want.sy, got.sy);
                    if (got.fault != want.fault) begin
                        $error("divide_fault exp %b got %b", want.fault, got.fault);
                        errors++;
                    end
                    if (got.sat != want.sat) begin
                        $error("saturated exp %b got %b", want.sat, got.sat);
                        errors++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
                $display("vertex_clip_ndc_viewport_core_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) mat_model[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        vp_w_model = vcv_pkg::VP_WIDTH_RST;
        vp_h_model = vcv_pkg::VP_HEIGHT_RST;
        send_idle_pct = 32;
        recv_idle_pct = 79;
        errors = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, extremes, zero clip w in all sign cases.
        push_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        push_load(4'd15, 32'h0);
        push_load(4'd3, 32'h0001_0000);
        push_vertex(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000);
        push_load(4'd0, 32'h7FFF_FFFF);
        push_load(4'd5, 32'h8000_0000);
        push_load(4'd12, 32'h8000_0000);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        for (int i = 0; i < 16; i++) push_load(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
        drain();
        write_cfg(vcv_pkg::CFG_VP_WIDTH, 13'd1);
        write_cfg(vcv_pkg::CFG_VP_HEIGHT, 13'd4096);
        push_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0001_0000);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001);
        push_random(600);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 32;
        write_cfg(vcv_pkg::CFG_VP_WIDTH, 13'd4096);
        write_cfg(vcv_pkg::CFG_VP_HEIGHT, 13'd1);
        push_random(600);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(vcv_pkg::CFG_VP_WIDTH, 13'h1FFF);
        write_cfg(vcv_pkg::CFG_VP_HEIGHT, 13'd0);
        push_random(300);
        drain();
        write_cfg(vcv_pkg::CFG_VP_WIDTH, 13'd1920);
        write_cfg(vcv_pkg::CFG_VP_HEIGHT, 13'd1080);
        push_random(300);
        drain();

        $display("covered %0d coefficient loads and %0d transforms", n_loads, n_xforms);
        $display("with %0d divide faults and %0d clamped results", n_faults, n_sats);
        if (errors == 0) begin
            $display("vertex_clip_ndc_viewport_core_tb: clean");
        end else begin
            $display("vertex_clip_ndc_viewport_core_tb: errors");
        end
        $finish;
    end
endmodule
